FILE: design/sorf_pkg.sv
`default_nettype none
package sorf_pkg;

  localparam int TableDepth    = 16;
  localparam int MaxDetections = 16;

  localparam logic [15:0] MinIntervalReset = 16'd100;
  localparam logic [15:0] MatchDistReset   = 16'd6400;
  localparam logic [9:0]  RadiusTolReset   = 10'd48;
  localparam logic [7:0]  StillLimitReset  = 8'd30;
  localparam logic [19:0] MaxAgeReset      = 20'd10000;

  typedef enum logic [2:0] {
    CFG_MIN_INTERVAL = 3'd0,
    CFG_MATCH_DIST   = 3'd1,
    CFG_RADIUS_TOL   = 3'd2,
    CFG_STILL_LIMIT  = 3'd3,
    CFG_MAX_AGE      = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [9:0]  r;
  } det_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [9:0]  r;
    logic [31:0] first_seen;
    logic [7:0]  count;
    logic        moving;
    logic        valid;
  } entry_t;

  typedef struct packed {
    logic [15:0] match_dist_sq;
    logic [9:0]  radius_tol;
    logic [7:0]  still_frame_limit;
    logic [19:0] max_age_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] t;
    logic        shift;
    logic        probe;
    logic        cleanup;
  } ctl_t;

  function automatic logic near(input det_t d, input entry_t e, input cfg_t c);
    logic [15:0] dx;
    logic [15:0] dy;
    logic [9:0]  dr;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [32:0] s;
    dx = (d.x > e.x) ? d.x - e.x : e.x - d.x;
    dy = (d.y > e.y) ? d.y - e.y : e.y - d.y;
    dr = (d.r > e.r) ? d.r - e.r : e.r - d.r;
    sx = {16'd0, dx} * {16'd0, dx};
    sy = {16'd0, dy} * {16'd0, dy};
    s  = {1'b0, sx} + {1'b0, sy};
    return (s < {17'd0, c.match_dist_sq}) && (dr < c.radius_tol);
  endfunction

endpackage
`default_nettype wire

FILE: design/sorf_if.sv
`default_nettype none
interface sorf_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/sorf_cell.sv
`default_nettype none
// One table slot. Probe: the detection travels down the row; the first
// matching cell claims it. Cleanup: dropped entries clear; on each compaction
// cycle the cells at and above the first hole take their upper neighbor.
module sorf_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sorf_pkg::cfg_t   cfg,
  input  wire sorf_pkg::ctl_t   ctl,
  input  wire sorf_pkg::det_t   det,
  input  wire logic             det_live_in,
  output      logic             det_live_out,
  input  wire logic             hole_in,
  output      logic             hole_out,
  input  wire sorf_pkg::entry_t up_entry,
  output      sorf_pkg::entry_t entry,
  output      logic             still_match,
  input  wire logic             insert_here
);
  import sorf_pkg::*;

  logic   close;
  logic   hit;
  logic   drop;
  logic   [31:0] age;

  assign close = near(det, entry, cfg);
  assign hit = det_live_in && entry.valid && close;
  assign det_live_out = det_live_in && !hit;
  assign hole_out = hole_in || !entry.valid;
  assign still_match = entry.valid && !entry.moving && close;
  assign age = ctl.t - entry.first_seen;
  assign drop = entry.valid &&
                (((entry.count > cfg.still_frame_limit) && !entry.moving) ||
                 ((ctl.t >= entry.first_seen) && (age > {12'd0, cfg.max_age_ms})));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctl.shift && hole_out) begin
      entry <= up_entry;
    end else if (ctl.cleanup && drop) begin
      entry.valid <= 1'b0;
    end else if (ctl.probe && hit) begin
      if (entry.count != 8'hFF) entry.count <= entry.count + 8'd1;
      entry.moving <= 1'b0;
    end else if (ctl.probe && insert_here) begin
      entry.x          <= det.x;
      entry.y          <= det.y;
      entry.r          <= det.r;
      entry.first_seen <= ctl.t;
      entry.count      <= 8'd1;
      entry.moving     <= 1'b1;
      entry.valid      <= 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: design/static_object_rejection_filter_unit.sv
`default_nettype none
// Input beats are taken one per cycle while collecting; a frame's results start
// only after its last beat, and input is held off until they have all left.
// Filtered frame: a probe step per detection, one cleanup step, compaction until
// no valid entry sits above a hole, then the reported beats; a pass-through frame
// goes straight to reporting. Reset empties the table and restores the defaults.
module static_object_rejection_filter_unit #(
  parameter int TABLE_DEPTH    = sorf_pkg::TableDepth,
  parameter int MAX_DETECTIONS = sorf_pkg::MaxDetections
) (
  input wire logic clk,
  input wire logic rst,
  sorf_if.sink   in_ch,
  sorf_if.sink   cfg_ch,
  sorf_if.source out_ch
);
  import sorf_pkg::*;

  localparam int DW = $clog2(MAX_DETECTIONS + 1);
  localparam int IW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;

  typedef enum logic [2:0] {S_COLLECT, S_PROBE, S_CLEAN, S_COMPACT, S_EMIT} st_t;

  st_t   st;
  cfg_t  cfg;
  logic  [15:0] min_interval;
  logic  [31:0] last_filter_time;
  logic  [31:0] t;
  det_t  dets [MAX_DETECTIONS];
  logic  [DW-1:0] nd;
  logic  [DW-1:0] idx;
  logic  unf;
  logic  ovf;
  ctl_t  ctl;
  entry_t ents [TABLE_DEPTH+1];
  logic  [TABLE_DEPTH:0] live;
  logic  [TABLE_DEPTH:0] gap;
  logic  [TABLE_DEPTH-1:0] ins;
  logic  [TABLE_DEPTH-1:0] still_v;
  logic  full;
  logic  hole;
  logic  still_hit;
  det_t  cur;
  det_t  in_det;
  logic  [31:0] in_t;
  logic  in_has;
  logic  in_last;
  logic  emit_this;
  det_t  pend;
  logic  have_pend;
  logic  [45:0] odata;
  logic  ovalid;

  assign in_det  = in_ch.data[75:34];
  assign in_t    = in_ch.data[33:2];
  assign in_has  = in_ch.data[1];
  assign in_last = in_ch.data[0];
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (st == S_COLLECT) && !ovalid;

  assign cur = dets[idx[IW-1:0]];
  assign ctl = '{t: t, shift: (st == S_COMPACT) && hole,
                 probe: (st == S_PROBE) && (idx < nd), cleanup: (st == S_CLEAN)};
  assign ents[TABLE_DEPTH] = '0;
  assign live[0] = 1'b1;
  assign gap[0] = 1'b0;
  assign full = !gap[TABLE_DEPTH];
  assign still_hit = |still_v;

  // A valid entry above a hole means compaction is not finished.
  always_comb begin
    hole = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++)
      if (gap[k] && ents[k].valid) hole = 1'b1;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_row
      if (g == 0) begin : g_first
        assign ins[g] = live[TABLE_DEPTH] && !ents[0].valid;
      end else begin : g_rest
        assign ins[g] = live[TABLE_DEPTH] && !ents[g].valid && ents[g-1].valid;
      end
      sorf_cell u_cell (
        .clk(clk), .rst(rst), .cfg(cfg), .ctl(ctl), .det(cur),
        .det_live_in(live[g]), .det_live_out(live[g+1]),
        .hole_in(gap[g]), .hole_out(gap[g+1]),
        .up_entry(ents[g+1]), .entry(ents[g]),
        .still_match(still_v[g]), .insert_here(ins[g])
      );
    end
  endgenerate

  assign emit_this = unf || !still_hit;
  assign out_ch.valid = ovalid;
  assign out_ch.data  = odata;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_COLLECT;
      nd <= '0;
      idx <= '0;
      have_pend <= 1'b0;
      ovalid <= 1'b0;
      last_filter_time <= '0;
      ovf <= 1'b0;
      unf <= 1'b0;
      min_interval <= MinIntervalReset;
      cfg.match_dist_sq <= MatchDistReset;
      cfg.radius_tol <= RadiusTolReset;
      cfg.still_frame_limit <= StillLimitReset;
      cfg.max_age_ms <= MaxAgeReset;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_index_t'(cfg_ch.data[22:20]))
          CFG_MIN_INTERVAL: min_interval <= cfg_ch.data[15:0];
          CFG_MATCH_DIST:   cfg.match_dist_sq <= cfg_ch.data[15:0];
          CFG_RADIUS_TOL:   cfg.radius_tol <= cfg_ch.data[9:0];
          CFG_STILL_LIMIT:  cfg.still_frame_limit <= cfg_ch.data[7:0];
          CFG_MAX_AGE:      cfg.max_age_ms <= cfg_ch.data[19:0];
          default: ;
        endcase
      end
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      case (st)
        S_COLLECT: if (in_ch.valid && in_ch.ready) begin
          if (in_has && (nd < DW'(MAX_DETECTIONS))) begin
            dets[nd[IW-1:0]] <= in_det;
            nd <= nd + 1'b1;
          end
          if (in_last) begin
            idx <= '0;
            have_pend <= 1'b0;
            ovf <= 1'b0;
            t <= in_t;
            if ((last_filter_time != 0) &&
                ((in_t < last_filter_time) ||
                 (in_t - last_filter_time < {16'd0, min_interval}))) begin
              unf <= 1'b1;
              st <= S_EMIT;
            end else begin
              unf <= 1'b0;
              st <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (idx < nd) begin
            if (live[TABLE_DEPTH] && full) ovf <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            idx <= '0;
            st <= S_CLEAN;
          end
        end
        S_CLEAN: st <= S_COMPACT;
        S_COMPACT: if (!hole) st <= S_EMIT;
        S_EMIT: if (!ovalid) begin
          if (idx < nd) begin
            if (emit_this) begin
              if (have_pend) begin
                ovalid <= 1'b1;
                odata <= {pend, 1'b1, 1'b0, unf, ovf};
              end
              pend <= cur;
              have_pend <= 1'b1;
            end
            idx <= idx + 1'b1;
          end else begin
            ovalid <= 1'b1;
            odata <= have_pend ? {pend, 1'b1, 1'b1, unf, ovf}
                               : {42'd0, 1'b0, 1'b1, unf, ovf};
            have_pend <= 1'b0;
            nd <= '0;
            if (!unf) last_filter_time <= t;
            st <= S_COLLECT;
          end
        end
        default: st <= S_COLLECT;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: test/tb_static_object_rejection_filter_unit.sv
`default_nettype none
module tb_static_object_rejection_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sorf_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [9:0]  r;
    logic [31:0] t;
    logic        has_ball;
    logic        last;
  } det_beat_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [9:0]  r;
    logic        ball_valid;
    logic        last;
    logic        unfiltered;
    logic        overflow;
  } report_t;

  typedef struct packed {
    cfg_index_t  idx;
    logic [19:0] value;
  } reg_write_t;

  class filter_scoreboard;
    logic [15:0] min_iv;
    logic [15:0] dist_sq;
    logic [9:0]  rad_tol;
    logic [7:0]  still_lim;
    logic [19:0] max_age;
    logic [31:0] last_t;
    entry_t      objs[TableDepth];
    det_t        pending[MaxDetections];
    int          n_pending;
    report_t     expected_q[$];
    int          errors;
    int          n_reports;
    int          n_frames;
    int          n_passed_through;
    int          n_overflow_frames;
    int          n_suppressed;

    function new();
      min_iv = MinIntervalReset;
      dist_sq = MatchDistReset;
      rad_tol = RadiusTolReset;
      still_lim = StillLimitReset;
      max_age = MaxAgeReset;
      last_t = '0;
      foreach (objs[k]) objs[k] = '0;
      n_pending = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [19:0] v);
      case (idx)
        CFG_MIN_INTERVAL: min_iv = v[15:0];
        CFG_MATCH_DIST:   dist_sq = v[15:0];
        CFG_RADIUS_TOL:   rad_tol = v[9:0];
        CFG_STILL_LIMIT:  still_lim = v[7:0];
        CFG_MAX_AGE:      max_age = v;
        default: ;
      endcase
    endfunction

    function bit is_near(det_t d, entry_t e);
      logic [63:0] dx, dy;
      logic [9:0]  dr;
      dx = (d.x > e.x) ? 64'(d.x - e.x) : 64'(e.x - d.x);
      dy = (d.y > e.y) ? 64'(d.y - e.y) : 64'(e.y - d.y);
      dr = (d.r > e.r) ? d.r - e.r : e.r - d.r;
      return (dx * dx + dy * dy < 64'(dist_sq)) && (dr < rad_tol);
    endfunction

    function int live_count();
      int n;
      n = 0;
      while (n < TableDepth && objs[n].valid) n++;
      return n;
    endfunction

    function void push(det_t d, logic bv, logic lst, logic unf, logic ovf);
      report_t o;
      o.x = d.x;
      o.y = d.y;
      o.r = d.r;
      o.ball_valid = bv;
      o.last = lst;
      o.unfiltered = unf;
      o.overflow = ovf;
      expected_q = {expected_q, o};
    endfunction

    function void note_input(det_beat_t b);
      int nd, n, w, first_out;
      bit hit, moving, drop, ovf;
      det_t d;
      if (b.has_ball && n_pending < MaxDetections) begin
        pending[n_pending] = '{x: b.x, y: b.y, r: b.r};
        n_pending++;
      end
      if (!b.last) return;
      nd = n_pending;
      n_pending = 0;
      n_frames++;
      if (last_t != 0 && (b.t < last_t || b.t - last_t < 32'(min_iv))) begin
        n_passed_through++;
        for (int i = 0; i < nd; i++) push(pending[i], 1'b1, i == nd - 1, 1'b1, 1'b0);
        if (nd == 0) push('0, 1'b0, 1'b1, 1'b1, 1'b0);
        return;
      end
      ovf = 0;
      for (int i = 0; i < nd; i++) begin
        d = pending[i];
        hit = 0;
        n = live_count();
        for (int k = 0; k < n; k++) begin
          if (is_near(d, objs[k])) begin
            if (objs[k].count != 8'hff) objs[k].count++;
            objs[k].moving = 0;
            hit = 1;
            break;
          end
        end
        if (!hit) begin
          if (n < TableDepth)
            objs[n] = '{x: d.x, y: d.y, r: d.r, first_seen: b.t, count: 8'd1,
                        moving: 1'b1, valid: 1'b1};
          else
            ovf = 1;
        end
      end
      n = live_count();
      w = 0;
      for (int k = 0; k < n; k++) begin
        drop = (objs[k].count > still_lim && !objs[k].moving) ||
               (b.t >= objs[k].first_seen && b.t - objs[k].first_seen > 32'(max_age));
        if (!drop) begin
          objs[w] = objs[k];
          w++;
        end
      end
      for (int k = w; k < TableDepth; k++) objs[k].valid = 0;
      first_out = expected_q.size();
      for (int i = 0; i < nd; i++) begin
        moving = 1;
        for (int k = 0; k < w; k++)
          if (!objs[k].moving && is_near(pending[i], objs[k])) begin
            moving = 0;
            break;
          end
        if (moving) push(pending[i], 1'b1, 1'b0, 1'b0, ovf);
        else n_suppressed++;
      end
      if (expected_q.size() == first_out) push('0, 1'b0, 1'b1, 1'b0, ovf);
      else expected_q[expected_q.size() - 1].last = 1;
      if (ovf) n_overflow_frames++;
      last_t = b.t;
    endfunction

    function void check_result(report_t got);
      report_t want;
      n_reports++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp x=%h y=%h r=%h v=%b l=%b u=%b o=%b, got x=%h y=%h r=%h v=%b l=%b u=%b o=%b",
                   want.x, want.y, want.r, want.ball_valid, want.last, want.unfiltered,
                   want.overflow, got.x, got.y, got.r, got.ball_valid, got.last,
                   got.unfiltered, got.overflow);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  sorf_if #(.W($bits(det_beat_t)))  in_ch();
  sorf_if #(.W($bits(reg_write_t))) cfg_ch();
  sorf_if #(.W($bits(report_t)))    out_ch();

  static_object_rejection_filter_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg_ch(cfg_ch), .out_ch(out_ch)
  );

  filter_scoreboard sb = new();
  int tx_idle;
  int rx_idle;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int n_items;
  logic [31:0] now_ms;
  det_t objects[6];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else if (hold_req && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(report_t'(out_ch.data));

  task automatic send_beat(det_beat_t b);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b);
    n_items++;
  endtask

  task automatic send_frame(int nd, logic [31:0] t, bit reuse);
    det_beat_t b;
    det_t d;
    if (nd == 0) begin
      b = '0;
      b.t = t;
      b.last = 1;
      send_beat(b);
      return;
    end
    for (int i = 0; i < nd; i++) begin
      if (reuse && $urandom_range(99) < 65) begin
        d = objects[$urandom_range(5)];
        d.x = d.x + 16'($urandom_range(4)) - 16'd2;
        d.y = d.y + 16'($urandom_range(4)) - 16'd2;
      end else begin
        d.x = $urandom;
        d.y = $urandom;
        d.r = $urandom;
      end
      b = '{x: d.x, y: d.y, r: d.r, t: t, has_ball: ($urandom_range(99) >= 8),
            last: (i == nd - 1)};
      send_beat(b);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] mi, logic [15:0] md, logic [9:0] rt,
                            logic [7:0] sl, logic [19:0] ma);
    reg_write_t w[5];
    w[0] = '{CFG_MIN_INTERVAL, 20'(mi)};
    w[1] = '{CFG_MATCH_DIST, 20'(md)};
    w[2] = '{CFG_RADIUS_TOL, 20'(rt)};
    w[3] = '{CFG_STILL_LIMIT, 20'(sl)};
    w[4] = '{CFG_MAX_AGE, ma};
    foreach (w[i]) begin
      cfg_ch.valid <= 1;
      cfg_ch.data <= w[i];
      do @(posedge clk); while (!cfg_ch.ready);
      sb.set_reg(w[i].idx, w[i].value);
    end
    cfg_ch.valid <= 0;
  endtask

  task automatic random_frames(int n_beats);
    int stop, nd, pick;
    stop = n_items + n_beats;
    while (n_items < stop) begin
      pick = $urandom_range(99);
      if (pick < 70) now_ms += 32'(sb.min_iv) + $urandom_range(300);
      else if (pick < 85) now_ms += $urandom_range(32'(sb.min_iv));
      else if (pick < 92 && now_ms > 50) now_ms -= $urandom_range(50);
      else now_ms += $urandom_range(20000);
      pick = $urandom_range(99);
      nd = (pick < 10) ? 0 : (pick < 95) ? $urandom_range(1, 5) : $urandom_range(6, 18);
      send_frame(nd, now_ms, $urandom_range(99) < 85);
    end
  endtask

  initial begin
    det_beat_t b;
    rst = 1;
    in_ch.valid <= 0;
    in_ch.data <= '0;
    cfg_ch.valid <= 0;
    cfg_ch.data <= '0;
    tx_idle = 24;
    rx_idle = 58;
    hold_req = 0;
    n_items = 0;
    foreach (objects[i]) objects[i] = '{x: $urandom_range(100, 65400),
                                        y: $urandom_range(100, 65400), r: $urandom};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // time zero filter, then a too-soon frame still filtered
    send_frame(1, 32'd0, 1);
    send_frame(2, 32'd5, 1);
    // empty frame and pass-through frame
    send_frame(0, 32'd200, 0);
    send_frame(2, 32'd250, 1);
    send_frame(0, 32'd260, 0);
    // extreme field values
    b = '{x: 16'hffff, y: 16'hffff, r: 10'h3ff, t: 32'd400, has_ball: 1, last: 0};
    send_beat(b);
    b = '{x: 16'h0, y: 16'h0, r: 10'h0, t: 32'd400, has_ball: 1, last: 1};
    send_beat(b);
    // same objects repeatedly: become still and get suppressed
    for (int f = 0; f < 3; f++) begin
      b = '{x: objects[0].x, y: objects[0].y, r: objects[0].r, t: 32'(600 + 150 * f),
            has_ball: 1, last: 1};
      send_beat(b);
    end
    // overfull buffer
    send_frame(18, 32'd1200, 0);
    now_ms = 32'd1400;

    hold_req = 1;
    random_frames(110);
    wait_drained();

    write_regs(16'd0, 16'hffff, 10'h3ff, 8'd0, 20'd0);
    tx_idle = 58;
    rx_idle = 24;
    random_frames(110);
    wait_drained();

    write_regs(16'hffff, 16'd0, 10'd0, 8'hff, 20'hfffff);
    random_frames(60);
    wait_drained();

    write_regs(16'($urandom_range(10, 400)), 16'($urandom_range(64, 20000)),
               10'($urandom_range(8, 200)), 8'($urandom_range(1, 6)),
               20'($urandom_range(500, 5000)));
    tx_idle = 0;
    rx_idle = 0;
    random_frames(130);
    // times near the top of the range; any later time reads as going backward
    send_frame(2, 32'hfffffff0, 1);
    send_frame(1, 32'hffffffff, 1);
    send_frame(1, 32'd3, 1);
    wait_drained();

    $display("%0d input beats, %0d frames (%0d passed through, %0d with table overflow)",
             n_items, sb.n_frames, sb.n_passed_through, sb.n_overflow_frames);
    $display("%0d result beats checked, %0d detections suppressed, %0d mismatches",
             sb.n_reports, sb.n_suppressed, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
